// ===== hdl/cordic_atan2_centidegree_assert.svh =====
// Assertion macros shared by the atan2 pipeline modules.
`ifndef CORDIC_ATAN2_CENTIDEGREE_ASSERT_SVH
`define CORDIC_ATAN2_CENTIDEGREE_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that cons holds in the same cycle as ante.
`define CAC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define CAC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CAC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define CAC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/cac_pkg.sv =====
package cac_pkg;

   localparam int STAGES     = 16;
   localparam int TABLE_LEN  = 16;
   localparam int IN_W       = 30;
   localparam int XY_W       = IN_W + 3;
   localparam int ANG_W      = 17;
   localparam int OUT_W      = 16;
   localparam int SHIFT_W    = $clog2(TABLE_LEN);
   localparam int REQ_DATA_W = ((2 * IN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((OUT_W + 7) / 8) * 8;

   localparam logic signed [ANG_W-1:0] HALF_TURN = 17'sd18000;
   localparam logic signed [ANG_W-1:0] FULL_TURN = 17'sd36000;

   localparam logic signed [ANG_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      17'sd4500, 17'sd2657, 17'sd1404, 17'sd713, 17'sd358, 17'sd179, 17'sd90, 17'sd45,
      17'sd22,   17'sd11,   17'sd6,    17'sd3,   17'sd1,   17'sd1,   17'sd0,  17'sd0
   };

   typedef struct packed {
      logic                    zero;
      logic signed [ANG_W-1:0] ang;
      logic signed [XY_W-1:0]  y;
      logic signed [XY_W-1:0]  x;
   } lane_type;

endpackage

// ===== hdl/cac_prep.sv =====
`include "cordic_atan2_centidegree_assert.svh"

module cac_prep
   import cac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [IN_W-1:0] coord_y,
   input  logic signed [IN_W-1:0] coord_x,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lane_type               out_lane
);

   logic     valid_ff, valid_in;
   lane_type lane_ff, lane_in;

   logic signed [XY_W-1:0] y_ext;
   logic signed [XY_W-1:0] x_ext;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      y_ext = XY_W'(coord_y);
      x_ext = XY_W'(coord_x);
      lane_in.zero = (coord_y == '0) && (coord_x == '0);
      if (coord_x[IN_W-1]) begin
         // left half plane: negate and start from a half turn
         lane_in.x   = -x_ext;
         lane_in.y   = -y_ext;
         lane_in.ang = (coord_y[IN_W-1] || coord_y == '0) ? HALF_TURN : -HALF_TURN;
      end else begin
         lane_in.x   = x_ext;
         lane_in.y   = y_ext;
         lane_in.ang = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

   `CAC_ASSERT_NEXT(a_prep_x_nonneg, clock, reset, in_valid && in_ready && coord_x[IN_W-1], !lane_ff.x[XY_W-1], "negative x left the pre-rotation")

endmodule

// ===== hdl/cac_cell.sv =====
`include "cordic_atan2_centidegree_assert.svh"

module cac_cell
   import cac_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [SHIFT_W-1:0]      shift,
   input  logic signed [ANG_W-1:0] step_angle,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lane_type                in_lane,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lane_type                out_lane
);

   logic     valid_ff, valid_in;
   lane_type lane_ff, lane_in;

   logic signed [XY_W-1:0] x_cur;
   logic signed [XY_W-1:0] y_cur;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic                   y_pos;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      x_cur = in_lane.x;
      y_cur = in_lane.y;
      xs    = x_cur >>> shift;
      ys    = y_cur >>> shift;
      y_pos = !y_cur[XY_W-1] && (y_cur != '0);
      lane_in.zero = in_lane.zero;
      // zero y takes the subtracting branch
      if (y_pos) begin
         lane_in.x   = x_cur + ys;
         lane_in.y   = y_cur - xs;
         lane_in.ang = in_lane.ang + step_angle;
      end else begin
         lane_in.x   = x_cur - ys;
         lane_in.y   = y_cur + xs;
         lane_in.ang = in_lane.ang - step_angle;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

   `CAC_ASSERT_NEXT(a_cell_hold, clock, reset, in_valid && in_ready, valid_ff, "transfer into cell was lost")

endmodule

// ===== hdl/cac_wrap.sv =====
`include "cordic_atan2_centidegree_assert.svh"

module cac_wrap
   import cac_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lane_type                in_lane,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [OUT_W-1:0] out_angle
);

   logic                    valid_ff, valid_in;
   logic signed [OUT_W-1:0] angle_ff, angle_in;
   logic signed [ANG_W-1:0] wrapped;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_lane.ang > HALF_TURN) begin
         wrapped = in_lane.ang - FULL_TURN;
      end else if (in_lane.ang < -HALF_TURN) begin
         wrapped = in_lane.ang + FULL_TURN;
      end else begin
         wrapped = in_lane.ang;
      end
      // both inputs zero: force the angle to zero
      angle_in = in_lane.zero ? '0 : wrapped[OUT_W-1:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;

   `CAC_ASSERT_NOW(a_wrap_range, clock, reset, valid_ff, (angle_ff <= 16'sd18000) && (angle_ff >= -16'sd18000), "angle outside half turn")
   `CAC_ASSERT_NEXT(a_wrap_zero, clock, reset, in_valid && in_ready && in_lane.zero, angle_ff == '0, "zero vector gave nonzero angle")

endmodule

// ===== hdl/cordic_atan2_centidegree.sv =====
// Data path: cac_prep register, one cac_cell register per iteration, cac_wrap register.
// Throughput: one item per cycle while rsp_tready is high, via the add-shift cell chain.
// Every stage has its own valid and ready, so bubbles close up under rsp_tready stalls.
// Reset (synchronous, active high) clears the stage valid bits; payload is not reset.
module cordic_atan2_centidegree
   import cac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // coord_y [29:0], coord_x [59:30], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // angle_centideg [15:0]
);

   lane_type lane_w  [STAGES+1];
   logic     valid_w [STAGES+1];
   logic     ready_w [STAGES+1];

   logic signed [OUT_W-1:0] angle;

   cac_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .coord_y   (req_tdata[IN_W-1:0]),
      .coord_x   (req_tdata[2*IN_W-1:IN_W]),
      .out_valid (valid_w[0]),
      .out_ready (ready_w[0]),
      .out_lane  (lane_w[0])
   );

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      cac_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (SHIFT_W'(i)),
         .step_angle (ATAN_TABLE[i]),
         .in_valid   (valid_w[i]),
         .in_ready   (ready_w[i]),
         .in_lane    (lane_w[i]),
         .out_valid  (valid_w[i+1]),
         .out_ready  (ready_w[i+1]),
         .out_lane   (lane_w[i+1])
      );
   end

   cac_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_w[STAGES]),
      .in_ready  (ready_w[STAGES]),
      .in_lane   (lane_w[STAGES]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_angle (angle)
   );

   assign rsp_tdata = RSP_DATA_W'(angle);

endmodule

// ===== tb/sv/cordic_atan2_centidegree_test.sv =====
`default_nettype none

module cordic_atan2_centidegree_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = cac_pkg::IN_W;
   localparam int AW          = cac_pkg::OUT_W;
   localparam int PIPE_DEPTH  = 18;
   localparam int QUIET_LIMIT = 2000;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [AW-1:0] angle_type;

   typedef struct {
      coord_type y;
      coord_type x;
      angle_type angle;
   } angle_expect_type;

   localparam coord_type COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(CW-1){1'b0}}};

   localparam longint HALF_TURN_CD = 18000;
   localparam int     ROTATIONS    = 16;
   localparam longint ARCTAN_CD [ROTATIONS] = '{
      4500, 2657, 1404, 713, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0
   };

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [cac_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // coord_y, coord_x, zero pad
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [cac_pkg::RSP_DATA_W-1:0] rsp_tdata;        // angle_centideg

   angle_expect_type expected_angles [$];
   int               error_count     = 0;
   int               quiet_cycles    = 0;
   int               stall_left      = 0;
   bit               sender_idling   = 1'b0;
   bit               receiver_idling = 1'b0;

   cordic_atan2_centidegree dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2ns clock = ~clock;

   function automatic angle_type atan2_centideg(input coord_type y_in, input coord_type x_in);
      longint y;
      longint x;
      longint ang;
      longint xs;
      longint ys;
      int     i;
      y   = y_in;
      x   = x_in;
      ang = 0;
      if (x == 0 && y == 0) begin
         return '0;
      end
      // fold the left half plane onto the right one
      if (x < 0) begin
         x   = -x;
         y   = -y;
         ang = (y >= 0) ? HALF_TURN_CD : -HALF_TURN_CD;
      end
      for (i = 0; i < ROTATIONS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x   = x + ys;
            y   = y - xs;
            ang = ang + ARCTAN_CD[i];
         end else begin
            x   = x - ys;
            y   = y + xs;
            ang = ang - ARCTAN_CD[i];
         end
      end
      if (ang > HALF_TURN_CD) begin
         ang = ang - 2 * HALF_TURN_CD;
      end else if (ang < -HALF_TURN_CD) begin
         ang = ang + 2 * HALF_TURN_CD;
      end
      return angle_type'(ang);
   endfunction

   // Mix of full-range values, short sign-extended values and the two extremes.
   function automatic coord_type random_coord();
      coord_type   v;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      v   = coord_type'($urandom);
      if (sel == 0) begin
         v = ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
      end else if (sel < 5) begin
         v = v >>> $urandom_range(1, CW - 1);
      end
      return v;
   endfunction

   task automatic send_pair(input coord_type y, input coord_type x);
      angle_expect_type item;
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(cac_pkg::REQ_DATA_W - 2 * CW){1'b0}}, x, y};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item.y     = y;
      item.x     = x;
      item.angle = atan2_centideg(y, x);
      expected_angles.push_back(item);
   endtask

   task automatic wait_drained();
      while (expected_angles.size() != 0) @(posedge clock);
   endtask

   // Zero vector, both axes, all four diagonals and the full-scale corners.
   task automatic test_directed();
      send_pair(0, 0);
      send_pair(0, 1);
      send_pair(0, COORD_MAX);
      send_pair(0, -1);
      send_pair(0, COORD_MIN);
      send_pair(1, 0);
      send_pair(COORD_MAX, 0);
      send_pair(-1, 0);
      send_pair(COORD_MIN, 0);
      send_pair(1, 1);
      send_pair(1, -1);
      send_pair(-1, 1);
      send_pair(-1, -1);
      send_pair(COORD_MAX, COORD_MAX);
      send_pair(COORD_MIN, COORD_MIN);
      send_pair(COORD_MAX, COORD_MIN);
      send_pair(COORD_MIN, COORD_MAX);
      send_pair(1, COORD_MIN);
      send_pair(-1, COORD_MIN);
      send_pair(COORD_MAX, 1);
      send_pair(COORD_MIN, -1);
      send_pair(1, COORD_MAX);
      send_pair(-1, COORD_MAX);
   endtask

   task automatic test_random_range(input int count);
      repeat (count) send_pair(random_coord(), random_coord());
   endtask

   // Vectors close to the negative x axis exercise the +/-18000 wrap;
   // vectors close to the y axis exercise the zero-x path.
   task automatic test_near_half_turn(input int count);
      coord_type y;
      coord_type x;
      repeat (count) begin
         if ($urandom_range(0, 2) != 0) begin
            x = random_coord();
            if (x > 0) begin
               x = -x;
            end else if (x == 0) begin
               x = -1;
            end
            y = coord_type'(int'($urandom_range(0, 6)) - 3);
         end else begin
            y = random_coord();
            x = coord_type'(int'($urandom_range(0, 4)) - 2);
         end
         send_pair(y, x);
      end
   endtask

   // Hold the sender until the pipeline is empty, then start again.
   task automatic test_drain_pauses();
      repeat (4) begin
         test_random_range(25);
         req_tvalid <= 1'b0;
         wait_drained();
      end
   endtask

   always @(posedge clock) begin
      if (reset || !receiver_idling) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      angle_expect_type want;
      angle_type        got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = angle_type'(rsp_tdata[AW-1:0]);
         if (expected_angles.size() == 0) begin
            error_count = error_count + 1;
            $error("angle_centideg: unexpected transfer, got %0d", got);
         end else begin
            want = expected_angles.pop_front();
            if (got !== want.angle) begin
               $error("angle_centideg: expected %0d, actual %0d (y=%0d x=%0d)",
                      want.angle, got, want.y, want.x);
               error_count = error_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idling = 1'b1;
      receiver_idling <= 1'b1;
      test_directed();
      test_random_range(400);
      test_near_half_turn(200);
      test_drain_pauses();

      // full-rate sender against a stalling receiver
      sender_idling = 1'b0;
      test_random_range(150);

      sender_idling = 1'b0;
      receiver_idling <= 1'b0;
      test_random_range(200);
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0 && expected_angles.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
